// File: hdl/rau_pkg.sv
package rau_pkg;

  // Operand and result widths
  localparam int OPW   = 16;
  localparam int PW    = 2 * OPW;
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;
  localparam int KW    = $clog2(PW + 1);
  localparam int CW    = $clog2(PW);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Multiplier step selects
  localparam logic [1:0] MUL_NUM0 = 2'd0;
  localparam logic [1:0] MUL_NUM1 = 2'd1;
  localparam logic [1:0] MUL_DEN  = 2'd2;

  // Divider target selects
  localparam logic DIV_NUM = 1'b0;
  localparam logic DIV_DEN = 1'b1;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_idx;
    logic       comb;
    logic       gcd_run;
    logic       div_start;
    logic       div_run;
    logic       div_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic gcd_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/rau_if.sv
interface rau_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic signed [15:0]      a_numerator;
  logic signed [15:0]      a_denominator;
  logic signed [15:0]      b_numerator;
  logic signed [15:0]      b_denominator;

  modport source (output valid, operation, a_numerator, a_denominator,
                  b_numerator, b_denominator, input ready);
  modport sink   (input valid, operation, a_numerator, a_denominator,
                  b_numerator, b_denominator, output ready);
endinterface

interface rau_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [32:0]      result_numerator;
  logic [30:0]             result_denominator;
  logic                    status;

  modport source (output valid, result_numerator, result_denominator, status,
                  input ready);
  modport sink   (input valid, result_numerator, result_denominator, status,
                  output ready);
endinterface

// File: hdl/rau_ctrl.sv
module rau_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd
);
  import rau_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_COMB   = 8'b0000_0100,
    S_GCD    = 8'b0000_1000,
    S_DIVN   = 8'b0001_0000,
    S_DSTART = 8'b0010_0000,
    S_DIVD   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t     state, state_next;
  logic [1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= MUL_NUM0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Sequencing of the datapath
  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.mul_idx = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          idx_next   = MUL_NUM0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.err) begin
          state_next = S_DONE;
        end else begin
          cmd.mul_en = 1'b1;
          idx_next   = idx + 2'd1;
          if (idx == MUL_DEN) state_next = S_COMB;
        end
      end
      S_COMB: begin
        cmd.comb   = 1'b1;
        state_next = S_GCD;
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_NUM;
          state_next    = S_DIVN;
        end else begin
          cmd.gcd_run = 1'b1;
        end
      end
      S_DIVN: begin
        cmd.div_run = 1'b1;
        cmd.div_sel = DIV_NUM;
        if (sts.div_done) state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DEN;
        state_next    = S_DIVD;
      end
      S_DIVD: begin
        cmd.div_run = 1'b1;
        cmd.div_sel = DIV_DEN;
        if (sts.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hdl/rau_dp.sv
module rau_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          operation,
  input  logic signed [15:0]  a_numerator,
  input  logic signed [15:0]  a_denominator,
  input  logic signed [15:0]  b_numerator,
  input  logic signed [15:0]  b_denominator,
  input  rau_pkg::cmd_t       cmd,
  output rau_pkg::sts_t       sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [rau_pkg::NUM_W-1:0] result_numerator,
  output logic [rau_pkg::DEN_W-1:0]        result_denominator,
  output logic                out_status
);
  import rau_pkg::*;

  // Input operands
  op_t                   op;
  logic signed [OPW-1:0] an, ad, bn, bd;
  logic                  err;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= op_t'(operation);
      an  <= a_numerator[OPW-1:0];
      ad  <= a_denominator[OPW-1:0];
      bn  <= b_numerator[OPW-1:0];
      bd  <= b_denominator[OPW-1:0];
      err <= (a_denominator[OPW-1:0] == '0) || (b_denominator[OPW-1:0] == '0) ||
             ((operation == OP_DIV) && (b_numerator[OPW-1:0] == '0));
    end
  end

  // Shared multiplier, one product a cycle
  logic signed [OPW-1:0] ma, mb;
  logic signed [PW-1:0]  p0, p1, p2, prod;

  always_comb begin
    unique case (cmd.mul_idx)
      MUL_NUM0: begin ma = an; mb = (op == OP_MUL) ? bn : bd; end
      MUL_NUM1: begin ma = bn; mb = ad; end
      default:  begin ma = ad; mb = (op == OP_DIV) ? bn : bd; end
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.mul_idx)
        MUL_NUM0: p0 <= prod;
        MUL_NUM1: p1 <= prod;
        default:  p2 <= prod;
      endcase
    end
  end

  // Combine cross products, split into sign and magnitude
  logic signed [PW:0] num_c;
  logic [PW-1:0]      nmag_c, dmag_c;
  logic [PW:0]        nabs;
  logic               neg_c;

  always_comb begin
    unique case (op)
      OP_ADD:  num_c = {p0[PW-1], p0} + {p1[PW-1], p1};
      OP_SUB:  num_c = {p0[PW-1], p0} - {p1[PW-1], p1};
      default: num_c = {p0[PW-1], p0};
    endcase
    nabs   = num_c[PW] ? (~num_c + 1'b1) : num_c;
    nmag_c = nabs[PW-1:0];
    dmag_c = p2[PW-1] ? (~p2 + 1'b1) : p2;
    neg_c  = (num_c[PW] ^ p2[PW-1]) && (nmag_c != '0);
  end

  logic [PW-1:0] nmag, dmag;
  logic          neg;

  always_ff @(posedge clk) begin
    if (cmd.comb) begin
      nmag <= nmag_c;
      dmag <= dmag_c;
      neg  <= neg_c;
    end
  end

  // Binary GCD: strip common twos, then subtract-and-halve
  logic [PW-1:0] gx, gy;
  logic [KW-1:0] gk;
  logic          strip;

  always_ff @(posedge clk) begin
    if (cmd.comb) begin
      gx    <= nmag_c;
      gy    <= dmag_c;
      gk    <= '0;
      strip <= 1'b1;
    end else if (cmd.gcd_run) begin
      if (strip) begin
        if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1;
          gy <= gy >> 1;
          gk <= gk + 1'b1;
        end else begin
          strip <= 1'b0;
        end
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx >= gy) begin
        gx <= (gx - gy) >> 1;
      end else begin
        gy <= (gy - gx) >> 1;
      end
    end
  end

  assign sts.gcd_done = (gx == '0);

  // Restoring divider by the GCD, one quotient bit a cycle
  logic [PW-1:0] gdiv, dv, dv_step;
  logic [PW:0]   rem, rem_sh, rem_step;
  logic [CW-1:0] cnt;
  logic          qbit;
  logic [PW-1:0] qn, qd;

  always_comb begin
    rem_sh   = {rem[PW-1:0], dv[PW-1]};
    qbit     = (rem_sh >= {1'b0, gdiv});
    rem_step = qbit ? (rem_sh - {1'b0, gdiv}) : rem_sh;
    dv_step  = {dv[PW-2:0], qbit};
  end

  assign sts.div_done = (cnt == CW'(PW - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      if (cmd.div_sel == DIV_NUM) gdiv <= gy << gk;
      dv  <= (cmd.div_sel == DIV_DEN) ? dmag : nmag;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_run) begin
      dv  <= dv_step;
      rem <= rem_step;
      cnt <= cnt + 1'b1;
      if (sts.div_done) begin
        if (cmd.div_sel == DIV_DEN) qd <= dv_step;
        else                        qn <= dv_step;
      end
    end
  end

  // Output register
  assign sts.err      = err;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (err) begin
        result_numerator   <= '0;
        result_denominator <= DEN_W'(1);
        out_status         <= 1'b1;
      end else begin
        result_numerator   <= neg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
        result_denominator <= qd[DEN_W-1:0];
        out_status         <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: add, subtract, multiply or divide two fractions, reduce by GCD.
// Steps: three products, combine, binary GCD, two divides (numerator, then denominator),
//   output load; inputs with a zero denominator or divisor skip straight to the output load.
// Throughput: one transaction at a time; a new one is taken only in idle, after the output load.
// Reset (rst, synchronous, active high) returns the controller to idle and
// empties the output register.
module rational_arithmetic_unit_top (
  input  logic      clk,
  input  logic      rst,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rau_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .operation          (in_ch.operation),
    .a_numerator        (in_ch.a_numerator),
    .a_denominator      (in_ch.a_denominator),
    .b_numerator        (in_ch.b_numerator),
    .b_denominator      (in_ch.b_denominator),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .result_numerator   (out_ch.result_numerator),
    .result_denominator (out_ch.result_denominator),
    .out_status         (out_ch.status)
  );

endmodule

// File: tb/tb_rational_arithmetic_unit_top.sv
module tb_rational_arithmetic_unit_top;
  import rau_pkg::*;

  typedef struct {
    op_t              operation;
    logic signed [15:0] an;
    logic signed [15:0] ad;
    logic signed [15:0] bn;
    logic signed [15:0] bd;
  } frac_op_t;

  typedef struct {
    logic signed [32:0] num;
    logic [30:0]        den;
    logic               status;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rau_in_if  in_ch();
  rau_out_if out_ch();

  rational_arithmetic_unit_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  frac_op_t  pending_ops[$];
  frac_res_t expected_results[$];
  int        mismatches = 0;
  int        idle_pct = 35;
  bit        stim_done = 1'b0;
  bit        hold_sender = 1'b0;
  bit        in_taken = 1'b0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Exact rational result, reduced, sign on the numerator
  function automatic frac_res_t rational_result(frac_op_t t);
    frac_res_t r;
    longint num, den;
    longint unsigned nm, dm, g;
    bit neg;
    r.num = '0; r.den = 31'd1; r.status = 1'b1;
    if (t.ad == 0 || t.bd == 0 || (t.operation == OP_DIV && t.bn == 0)) return r;
    unique case (t.operation)
      OP_ADD: begin num = t.an * t.bd + t.bn * t.ad; den = t.ad * t.bd; end
      OP_SUB: begin num = t.an * t.bd - t.bn * t.ad; den = t.ad * t.bd; end
      OP_MUL: begin num = t.an * t.bn; den = t.ad * t.bd; end
      default: begin num = t.an * t.bd; den = t.ad * t.bn; end
    endcase
    nm = num < 0 ? -num : num;
    dm = den < 0 ? -den : den;
    g = gcd_of(nm, dm);
    if (g == 0) g = 1;
    nm = nm / g;
    dm = dm / g;
    neg = (num < 0) != (den < 0);
    if (nm == 0) neg = 1'b0;
    r.num = neg ? 33'(-nm) : 33'(nm);
    r.den = dm[30:0];
    r.status = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] rand_operand();
    unique case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_op(op_t o, int an, int ad, int bn, int bd);
    frac_op_t t;
    t.operation = o; t.an = 16'(an); t.ad = 16'(ad); t.bn = 16'(bn); t.bd = 16'(bd);
    pending_ops.push_back(t);
  endtask

  // Driver: new transaction presented at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_ops.size() > 0 && !hold_sender &&
          $urandom_range(0, 99) >= idle_pct) begin
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= pending_ops[0].operation;
        in_ch.a_numerator   <= pending_ops[0].an;
        in_ch.a_denominator <= pending_ops[0].ad;
        in_ch.b_numerator   <= pending_ops[0].bn;
        in_ch.b_denominator <= pending_ops[0].bd;
        pending_ops.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Sink back-pressure
  always @(negedge clk) begin
    out_ch.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= idle_pct);
  end

  // Accepted inputs feed the predictor
  always @(posedge clk) begin
    frac_op_t t;
    in_taken = !rst && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      t.operation = op_t'(in_ch.operation);
      t.an = in_ch.a_numerator; t.ad = in_ch.a_denominator;
      t.bn = in_ch.b_numerator; t.bd = in_ch.b_denominator;
      expected_results.push_back(rational_result(t));
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    frac_res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d st %0d",
          out_ch.result_numerator, out_ch.result_denominator, out_ch.status);
      end else begin
        e = expected_results.pop_front();
        if (out_ch.result_numerator !== e.num || out_ch.result_denominator !== e.den ||
            out_ch.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
              e.num, e.den, e.status, out_ch.result_numerator,
              out_ch.result_denominator, out_ch.status);
        end
      end
    end
  end

  // Stimulus
  initial begin
    frac_op_t t;
    in_ch.valid = 1'b0; in_ch.operation = '0;
    in_ch.a_numerator = '0; in_ch.a_denominator = 16'd1;
    in_ch.b_numerator = '0; in_ch.b_denominator = 16'd1;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, each operation, error and zero cases
    add_op(OP_ADD, 1, 2, 1, 3);
    add_op(OP_SUB, 1, 2, 1, 2);
    add_op(OP_MUL, -3, 4, 8, -9);
    add_op(OP_DIV, 2, 3, -4, 5);
    add_op(OP_DIV, 5, 7, 0, 3);
    add_op(OP_ADD, 1, 0, 1, 1);
    add_op(OP_MUL, 1, 1, 1, 0);
    add_op(OP_SUB, 0, -5, 0, 7);
    add_op(OP_ADD, -32768, 1, -32768, 1);
    add_op(OP_SUB, -32768, 1, 32767, 1);
    add_op(OP_MUL, -32768, 1, -32768, 1);
    add_op(OP_MUL, 1, -32768, 1, -32768);
    add_op(OP_DIV, -32768, 1, 1, -32768);
    add_op(OP_DIV, 32767, -32768, -32768, 32767);
    add_op(OP_ADD, 32767, 32767, 32767, -32768);
    add_op(OP_ADD, 32767, -32767, -32768, 32767);
    add_op(OP_SUB, -1, -1, -1, -1);
    add_op(OP_DIV, 0, 1, 1, 1);
    add_op(OP_MUL, 0, -32768, 5, 3);
    add_op(OP_ADD, 12, 18, -4, 6);

    // Let everything drain before random traffic
    wait (pending_ops.size() == 0 && !in_ch.valid);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0);
    @(negedge clk);
    hold_sender = 1'b0;

    for (int i = 0; i < 1850; i++) begin
      t.operation = op_t'($urandom_range(0, 3));
      t.an = rand_operand(); t.ad = rand_operand();
      t.bn = rand_operand(); t.bd = rand_operand();
      pending_ops.push_back(t);
      // No idling for a stretch in the middle
      if (i == 600) begin
        wait (pending_ops.size() < 50);
        idle_pct = 0;
      end
      if (i == 900) begin
        wait (pending_ops.size() < 50);
        idle_pct = 35;
      end
    end
    wait (pending_ops.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
